// ----- rtl/ssp_pkg.sv -----
// shared types, constants and divider sizing for the sprite projection core
// no dependencies
`default_nettype none

package ssp_pkg;

  localparam int SCREEN_HEIGHT = 480;
  localparam int SCREEN_WIDTH  = 640;

  localparam logic signed [16:0] H_HALF = 17'(SCREEN_HEIGHT / 2);
  localparam logic signed [16:0] H_LAST = 17'(SCREEN_HEIGHT - 1);
  localparam logic signed [16:0] W_LAST = 17'(SCREEN_WIDTH - 1);
  localparam logic [15:0]        W_HALF = 16'(SCREEN_WIDTH / 2);

  // divider: unsigned dividend, divisor, quotient bits kept before saturation
  localparam int DIV_NW = 48;
  localparam int DIV_DW = 40;
  localparam int DIV_QB = 16;

  localparam logic [2:0] REG_PLAYER_X = 3'd0;
  localparam logic [2:0] REG_PLAYER_Y = 3'd1;
  localparam logic [2:0] REG_DIR_X    = 3'd2;
  localparam logic [2:0] REG_DIR_Y    = 3'd3;
  localparam logic [2:0] REG_PLANE_X  = 3'd4;
  localparam logic [2:0] REG_PLANE_Y  = 3'd5;

  typedef struct packed {
    logic [15:0]        player_x;
    logic [15:0]        player_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] plane_x;
    logic signed [15:0] plane_y;
    logic signed [32:0] det;
  } cam_t;

  typedef struct packed {
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
    logic              neg;
  } div_req_t;

  typedef struct packed {
    logic [DIV_QB-1:0] quo;
    logic              ovf;
    logic              neg;
  } div_rsp_t;

  typedef struct packed {
    logic [5:0] tag;
    logic       front;
    logic       det_nz;
    logic       ny_nz;
  } side_t;

endpackage

`default_nettype wire

// ----- rtl/ssp_cfg.sv -----
// camera register file with apb-style write/read and registered determinant
// depends on ssp_pkg
`default_nettype none

module ssp_cfg
  import ssp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output cam_t             cam
);

  localparam logic signed [32:0] DET_RST = 33'sd177160192;

  logic [15:0]        player_x_r, player_y_r;
  logic signed [15:0] dir_x_r, dir_y_r, plane_x_r, plane_y_r;
  logic signed [32:0] det_r, det_nxt;
  logic signed [31:0] prod_a, prod_b;
  logic [2:0]         idx;
  logic               wr;

  assign idx = paddr[4:2];
  assign wr  = psel & penable & pwrite;

  assign prod_a  = plane_x_r * dir_y_r;
  assign prod_b  = plane_y_r * dir_x_r;
  assign det_nxt = {prod_a[31], prod_a} - {prod_b[31], prod_b};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      player_x_r <= '0;
      player_y_r <= '0;
      dir_x_r    <= -16'sd16384;
      dir_y_r    <= '0;
      plane_x_r  <= '0;
      plane_y_r  <= 16'sd10813;
      det_r      <= DET_RST;
    end else begin
      det_r <= det_nxt;
      if (wr) begin
        unique case (idx)
          REG_PLAYER_X: player_x_r <= pwdata[15:0];
          REG_PLAYER_Y: player_y_r <= pwdata[15:0];
          REG_DIR_X:    dir_x_r    <= pwdata[15:0];
          REG_DIR_Y:    dir_y_r    <= pwdata[15:0];
          REG_PLANE_X:  plane_x_r  <= pwdata[15:0];
          REG_PLANE_Y:  plane_y_r  <= pwdata[15:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (idx)
      REG_PLAYER_X: prdata = {16'd0, player_x_r};
      REG_PLAYER_Y: prdata = {16'd0, player_y_r};
      REG_DIR_X:    prdata = {16'd0, dir_x_r};
      REG_DIR_Y:    prdata = {16'd0, dir_y_r};
      REG_PLANE_X:  prdata = {16'd0, plane_x_r};
      REG_PLANE_Y:  prdata = {16'd0, plane_y_r};
      default:      prdata = '0;
    endcase
  end

  assign cam = '{player_x: player_x_r, player_y: player_y_r, dir_x: dir_x_r,
                 dir_y: dir_y_r, plane_x: plane_x_r, plane_y: plane_y_r, det: det_r};

endmodule

`default_nettype wire

// ----- rtl/ssp_front.sv -----
// front pipeline: offset, camera products, numerators, divider operands
// depends on ssp_pkg
`default_nettype none

module ssp_front
  import ssp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        adv,
  input  wire logic        in_valid,
  input  wire logic [5:0]  in_tag,
  input  wire logic [15:0] in_sx,
  input  wire logic [15:0] in_sy,
  input  cam_t             cam,
  output logic             valid,
  output side_t            side,
  output div_req_t         req_dep,
  output div_req_t         req_col,
  output div_req_t         req_siz
);

  logic               v1_r, v2_r, v3_r, v4_r;
  logic [5:0]         tag1_r, tag2_r, tag3_r;
  logic signed [16:0] dx1_r, dy1_r;
  logic signed [32:0] p1_r, p2_r, p3_r, p4_r;
  logic signed [33:0] nx3_r, ny3_r;
  side_t              side4_r, side4_nxt;
  div_req_t           dep4_r, col4_r, siz4_r, dep4_nxt, col4_nxt, siz4_nxt;

  logic               ny_neg, det_neg, sum_neg;
  logic [33:0]        ny_mag;
  logic [32:0]        det_mag;
  logic signed [34:0] sum;
  logic [34:0]        sum_mag;
  logic               det_nz, ny_nz, front;

  always_comb begin
    ny_neg  = ny3_r[33];
    det_neg = cam.det[32];
    ny_mag  = ny_neg ? 34'(-ny3_r) : 34'(ny3_r);
    det_mag = det_neg ? 33'(-cam.det) : 33'(cam.det);
    sum     = {nx3_r[33], nx3_r} + {ny3_r[33], ny3_r};
    sum_neg = sum[34];
    sum_mag = sum_neg ? 35'(-sum) : 35'(sum);
    det_nz  = (cam.det != '0);
    ny_nz   = (ny3_r != '0);
    front   = det_nz && ny_nz && (ny_neg == det_neg);

    side4_nxt = '{tag: tag3_r, front: front, det_nz: det_nz, ny_nz: ny_nz};

    dep4_nxt.num = DIV_NW'(ny_mag) << 14;
    dep4_nxt.den = det_nz ? DIV_DW'(det_mag) : DIV_DW'(1);
    dep4_nxt.neg = ny_neg ^ det_neg;

    col4_nxt.num = DIV_NW'(sum_mag) * DIV_NW'(SCREEN_WIDTH / 2);
    col4_nxt.den = ny_nz ? DIV_DW'(ny_mag) : DIV_DW'(1);
    col4_nxt.neg = sum_neg ^ ny_neg;

    siz4_nxt.num = DIV_NW'(det_mag) * DIV_NW'(SCREEN_HEIGHT);
    siz4_nxt.den = front ? (DIV_DW'(ny_mag) << 6) : DIV_DW'(1);
    siz4_nxt.neg = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag1_r  <= in_tag;
      dx1_r   <= $signed({1'b0, in_sx}) - $signed({1'b0, cam.player_x});
      dy1_r   <= $signed({1'b0, in_sy}) - $signed({1'b0, cam.player_y});
      tag2_r  <= tag1_r;
      p1_r    <= cam.dir_y * dx1_r;
      p2_r    <= cam.dir_x * dy1_r;
      p3_r    <= cam.plane_y * dx1_r;
      p4_r    <= cam.plane_x * dy1_r;
      tag3_r  <= tag2_r;
      nx3_r   <= {p1_r[32], p1_r} - {p2_r[32], p2_r};
      ny3_r   <= {p4_r[32], p4_r} - {p3_r[32], p3_r};
      side4_r <= side4_nxt;
      dep4_r  <= dep4_nxt;
      col4_r  <= col4_nxt;
      siz4_r  <= siz4_nxt;
    end
  end

  assign valid   = v4_r;
  assign side    = side4_r;
  assign req_dep = dep4_r;
  assign req_col = col4_r;
  assign req_siz = siz4_r;

endmodule

`default_nettype wire

// ----- rtl/ssp_div.sv -----
// pipelined restoring divider, one quotient bit per stage, overflow flag
// depends on ssp_pkg
`default_nettype none

module ssp_div
  import ssp_pkg::*;
(
  input  wire logic clk,
  input  wire logic adv,
  input  div_req_t  req,
  output div_rsp_t  rsp
);

  logic [DIV_DW-1:0] rem_r [DIV_QB];
  logic [DIV_DW-1:0] den_r [DIV_QB];
  logic [DIV_QB-1:0] lo_r  [DIV_QB];
  logic [DIV_QB-1:0] quo_r [DIV_QB+1];
  logic              ovf_r [DIV_QB+1];
  logic              neg_r [DIV_QB+1];

  logic [DIV_DW:0]   cand  [DIV_QB];
  logic [DIV_DW:0]   diff  [DIV_QB];
  logic              ge    [DIV_QB];
  logic [DIV_DW-1:0] top;

  assign top = DIV_DW'(req.num[DIV_NW-1:DIV_QB]);

  always_comb begin
    for (int i = 0; i < DIV_QB; i++) begin
      cand[i] = {rem_r[i], lo_r[i][DIV_QB-1]};
      diff[i] = cand[i] - {1'b0, den_r[i]};
      ge[i]   = (cand[i] >= {1'b0, den_r[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= top;
      den_r[0] <= req.den;
      lo_r[0]  <= req.num[DIV_QB-1:0];
      quo_r[0] <= '0;
      ovf_r[0] <= (top >= req.den);
      neg_r[0] <= req.neg;
      for (int i = 0; i < DIV_QB; i++) begin
        quo_r[i+1] <= {quo_r[i][DIV_QB-2:0], ge[i]};
        ovf_r[i+1] <= ovf_r[i];
        neg_r[i+1] <= neg_r[i];
        if (i < DIV_QB - 1) begin
          rem_r[i+1] <= ge[i] ? diff[i][DIV_DW-1:0] : cand[i][DIV_DW-1:0];
          den_r[i+1] <= den_r[i];
          lo_r[i+1]  <= lo_r[i] << 1;
        end
      end
    end
  end

  assign rsp = '{quo: quo_r[DIV_QB], ovf: ovf_r[DIV_QB], neg: neg_r[DIV_QB]};

endmodule

`default_nettype wire

// ----- rtl/ssp_back.sv -----
// back pipeline: quotient saturation, then draw bounds into the output register
// depends on ssp_pkg
`default_nettype none

module ssp_back
  import ssp_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          adv,
  input  wire logic          in_valid,
  input  side_t              side,
  input  div_rsp_t           rsp_dep,
  input  div_rsp_t           rsp_col,
  input  div_rsp_t           rsp_siz,
  output logic               out_valid,
  output logic [5:0]         tag_out,
  output logic               in_front,
  output logic signed [15:0] depth,
  output logic signed [15:0] screen_column,
  output logic [14:0]        sprite_size,
  output logic [7:0]         start_row,
  output logic [8:0]         end_row,
  output logic [14:0]        start_col,
  output logic signed [15:0] end_col
);

  function automatic logic [15:0] sat16(input div_rsp_t r);
    logic [15:0] res;
    if (r.neg) begin
      if (r.ovf || r.quo > 16'd32768) res = 16'h8000;
      else res = ~r.quo + 16'd1;
    end else begin
      if (r.ovf || r.quo > 16'd32767) res = 16'h7FFF;
      else res = r.quo;
    end
    return res;
  endfunction

  logic               vf_r, vg_r;
  logic [5:0]         tagf_r, tagg_r;
  logic               frontf_r, frontg_r;
  logic [15:0]        depf_r, depg_r;
  logic [15:0]        colf_r, colg_r;
  logic [14:0]        sizf_r, sizg_r;
  logic [7:0]         srow_r, srow_nxt;
  logic [8:0]         erow_r, erow_nxt;
  logic [14:0]        scol_r, scol_nxt;
  logic [15:0]        ecol_r, ecol_nxt;
  logic [13:0]        half;
  logic signed [16:0] srow_w, erow_w, scol_w, ecol_w;

  always_comb begin
    half   = sizf_r[14:1];
    srow_w = H_HALF - $signed({3'b0, half});
    erow_w = H_HALF + $signed({3'b0, half});
    scol_w = $signed({colf_r[15], colf_r}) - $signed({3'b0, half});
    ecol_w = $signed({colf_r[15], colf_r}) + $signed({3'b0, half});
    srow_nxt = (srow_w < 0) ? 8'd0 : srow_w[7:0];
    erow_nxt = (erow_w > H_LAST) ? H_LAST[8:0] : erow_w[8:0];
    scol_nxt = (scol_w < 0) ? 15'd0 : scol_w[14:0];
    ecol_nxt = (ecol_w > W_LAST) ? W_LAST[15:0] : ecol_w[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
      vg_r <= 1'b0;
    end else if (adv) begin
      vf_r <= in_valid;
      vg_r <= vf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tagf_r   <= side.tag;
      frontf_r <= side.front;
      depf_r   <= side.det_nz ? sat16(rsp_dep) : 16'd0;
      colf_r   <= side.ny_nz ? sat16(rsp_col) : W_HALF;
      if (!side.front) sizf_r <= 15'd0;
      else if (rsp_siz.ovf || rsp_siz.quo > 16'd32767) sizf_r <= 15'h7FFF;
      else sizf_r <= rsp_siz.quo[14:0];
      tagg_r   <= tagf_r;
      frontg_r <= frontf_r;
      depg_r   <= depf_r;
      colg_r   <= colf_r;
      sizg_r   <= sizf_r;
      srow_r   <= srow_nxt;
      erow_r   <= erow_nxt;
      scol_r   <= scol_nxt;
      ecol_r   <= ecol_nxt;
    end
  end

  assign out_valid     = vg_r;
  assign tag_out       = tagg_r;
  assign in_front      = frontg_r;
  assign depth         = depg_r;
  assign screen_column = colg_r;
  assign sprite_size   = sizg_r;
  assign start_row     = srow_r;
  assign end_row       = erow_r;
  assign start_col     = scol_r;
  assign end_col       = ecol_r;

endmodule

`default_nettype wire

// ----- rtl/sprite_screen_projection_core.sv -----
// top level of the billboard sprite projection pipeline
// depends on ssp_pkg, ssp_cfg, ssp_front, ssp_div, ssp_back
//
//   channel | dir | beat
//   in_     | in  | tdata: sprite_id, sprite_x, sprite_y
//   out_    | out | tdata: projection and bounds, tuser: in_front
//   cfg_    | in  | apb-style camera register access
//
// one sprite per cycle while no result waits on out_tready; sprites pass front, divider, back
// the divider stages, one quotient bit each, set the depth
// rst_n is synchronous; it clears the valid bits and resets the camera registers to defaults
// the whole pipeline holds while a result waits; in_tready follows that hold
`default_nettype none

module sprite_screen_projection_core
  import ssp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [39:0]  in_tdata,   // sprite_id, sprite_x, sprite_y, pad
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [103:0]      out_tdata,  // tag_out, depth, screen_column, sprite_size,
                                        // start_row, end_row, start_col, end_col, pad
  output logic [0:0]        out_tuser,  // in_front
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [4:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic               adv;
  cam_t               cam;
  logic               fv;
  side_t              fside;
  div_req_t           req_dep, req_col, req_siz;
  div_rsp_t           rsp_dep, rsp_col, rsp_siz;
  side_t              sd_r [DIV_QB+1];
  logic               vd_r [DIV_QB+1];

  logic [5:0]         tag_out;
  logic               in_front;
  logic signed [15:0] depth, screen_column, end_col;
  logic [14:0]        sprite_size, start_col;
  logic [7:0]         start_row;
  logic [8:0]         end_row;

  assign adv        = !out_tvalid || out_tready;
  assign in_tready  = adv;
  assign cfg_pready = 1'b1;

  ssp_cfg u_cfg (
    .clk, .rst_n, .psel(cfg_psel), .penable(cfg_penable), .pwrite(cfg_pwrite),
    .paddr(cfg_paddr), .pwdata(cfg_pwdata), .prdata(cfg_prdata), .cam
  );

  ssp_front u_front (
    .clk, .rst_n, .adv, .in_valid(in_tvalid), .in_tag(in_tdata[5:0]),
    .in_sx(in_tdata[21:6]), .in_sy(in_tdata[37:22]), .cam, .valid(fv), .side(fside),
    .req_dep, .req_col, .req_siz
  );

  ssp_div u_div_dep (.clk, .adv, .req(req_dep), .rsp(rsp_dep));
  ssp_div u_div_col (.clk, .adv, .req(req_col), .rsp(rsp_col));
  ssp_div u_div_siz (.clk, .adv, .req(req_siz), .rsp(rsp_siz));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= DIV_QB; i++) vd_r[i] <= 1'b0;
    end else if (adv) begin
      vd_r[0] <= fv;
      for (int i = 1; i <= DIV_QB; i++) vd_r[i] <= vd_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd_r[0] <= fside;
      for (int i = 1; i <= DIV_QB; i++) sd_r[i] <= sd_r[i-1];
    end
  end

  ssp_back u_back (
    .clk, .rst_n, .adv, .in_valid(vd_r[DIV_QB]), .side(sd_r[DIV_QB]),
    .rsp_dep, .rsp_col, .rsp_siz, .out_valid(out_tvalid), .tag_out, .in_front,
    .depth, .screen_column, .sprite_size, .start_row, .end_row, .start_col, .end_col
  );

  assign out_tdata = {3'b0, end_col, start_col, end_row, start_row, sprite_size,
                      screen_column, depth, tag_out};
  assign out_tuser = in_front;

  a_behind_no_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !in_front |-> sprite_size == 15'd0)
    else $error("sprite behind camera with nonzero size");

  a_rows_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> {1'b0, start_row} <= end_row)
    else $error("start row past end row");

  a_zero_size_rows: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && sprite_size == 15'd0 |->
      {1'b0, start_row} == H_HALF[8:0] && end_row == H_HALF[8:0])
    else $error("zero size sprite rows not centered");

endmodule

`default_nettype wire
